/* rtl/key_tap_dance_tracker_unit_assert.svh */
// assertion macros for the tap-dance tracker
`ifndef KEY_TAP_DANCE_TRACKER_UNIT_ASSERT_SVH
`define KEY_TAP_DANCE_TRACKER_UNIT_ASSERT_SVH

// implication checked in the same cycle
`define KTD_ASSERT_SAME(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("ktd check failed");

// implication checked in the next cycle
`define KTD_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("ktd check failed");

`endif

/* rtl/ktd_pkg.sv */
// shared types and constants of the tap-dance tracker
package ktd_pkg;
	localparam int ENTRIES = 10;
	localparam int MAX_BINDINGS = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = 5;
	localparam int TERM_W = 16;
	localparam int TIME_W = 32;
	localparam int POS_W = 8;
	localparam int WORD_W = POS_W + CNT_W + 1 + TIME_W;
	localparam logic [TERM_W-1:0] TERM_RESET = 16'd200;
	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

	localparam logic [1:0] FN_PRESS = 2'd0;
	localparam logic [1:0] FN_RELEASE = 2'd1;
	localparam logic [1:0] FN_OTHER = 2'd2;
	localparam logic [1:0] FN_TICK = 2'd3;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_PRESS = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;

	localparam logic [1:0] REG_TERM = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
		logic              held;
		logic [TIME_W-1:0] dl;
	} entry_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [3:0]        binding_index;
		logic [POS_W-1:0]  position;
		logic [TIME_W-1:0] time_ms;
		logic [1:0]        status;
		logic              last;
	} result_t;
endpackage

/* rtl/ktd_ram.sv */
// generic single-write, single-read ram with registered read
module ktd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* rtl/ktd_engine.sv */
// per-item scan sequencer: reads each entry, updates flags, writes the matched or new entry, emits results
module ktd_engine import ktd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_go,
	input  logic [1:0]        func,
	input  logic [POS_W-1:0]  key_position,
	input  logic [TIME_W-1:0] time_ms,
	input  logic [TERM_W-1:0] term,
	input  logic [CNT_W-1:0]  bcount,
	input  logic              out_ok,
	output logic              busy,
	output logic              push,
	output result_t           res,
	output logic              we,
	output logic [IDX_W-1:0]  waddr,
	output entry_t            wdata,
	output logic [IDX_W-1:0]  raddr,
	input  entry_t            rdata
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_EV   = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [1:0]        func_q;
	logic [POS_W-1:0]  pos_q;
	logic [TIME_W-1:0] t_q;
	logic [IDX_W-1:0]  idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  fidx_q;
	entry_t            fdata_q;
	logic              pend_q;
	result_t           pend_res_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] armed_q;

	logic              hit, expired, tick_emit, ev_go, fin_go;
	logic              free_ok;
	logic [IDX_W-1:0]  free_idx;
	logic [CNT_W-1:0]  eff, base_cnt, new_cnt;
	logic [IDX_W-1:0]  tgt_idx;
	logic [TIME_W-1:0] diff;
	result_t           tick_res;

	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_ok = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	always_comb begin
		eff = bcount;
		if (bcount == '0) eff = CNT_W'(1);
		if (bcount > CNT_W'(MAX_BINDINGS)) eff = CNT_W'(MAX_BINDINGS);
		base_cnt = found_q ? fdata_q.cnt : '0;
		new_cnt = (base_cnt < eff) ? base_cnt + CNT_W'(1) : base_cnt;
		tgt_idx = found_q ? fidx_q : free_idx;
	end

	assign hit = valid_q[idx_q] && (rdata.pos == pos_q);
	assign diff = t_q - rdata.dl;
	assign expired = valid_q[idx_q] && armed_q[idx_q] && !diff[TIME_W-1];
	assign tick_emit = (func_q == FN_TICK) && expired && !rdata.held;
	// a second expiry pushes out the held one first
	assign ev_go = !(tick_emit && pend_q) || out_ok;

	always_comb begin
		tick_res.action = ACT_RELEASE;
		tick_res.binding_index = 4'(rdata.cnt - CNT_W'(1));
		tick_res.position = rdata.pos;
		tick_res.time_ms = rdata.dl;
		tick_res.status = ST_OK;
		tick_res.last = 1'b0;
	end

	always_comb begin
		push = 1'b0;
		res = pend_res_q;
		we = 1'b0;
		waddr = tgt_idx;
		wdata = fdata_q;
		fin_go = 1'b1;
		if (state_q == S_EV && tick_emit && pend_q) begin
			push = out_ok;
		end
		if (state_q == S_FIN) begin
			res.position = pos_q;
			res.time_ms = t_q;
			res.status = ST_OK;
			res.last = 1'b1;
			res.binding_index = '0;
			res.action = ACT_NONE;
			case (func_q)
				FN_PRESS: begin
					fin_go = out_ok;
					push = out_ok;
					if (!found_q && !free_ok) begin
						res.status = ST_FULL;
					end else begin
						res.action = ACT_PRESS;
						res.binding_index = 4'(new_cnt - CNT_W'(1));
						we = out_ok;
						wdata.pos = pos_q;
						wdata.cnt = new_cnt;
						wdata.held = 1'b1;
						wdata.dl = t_q + TIME_W'(term);
					end
				end
				FN_RELEASE: begin
					fin_go = out_ok;
					push = out_ok;
					if (!found_q) begin
						res.status = ST_NO_ENTRY;
					end else begin
						res.action = ACT_RELEASE;
						res.binding_index = 4'(fdata_q.cnt - CNT_W'(1));
						we = out_ok;
						wdata.held = 1'b0;
					end
				end
				FN_TICK: begin
					res = pend_res_q;
					res.last = 1'b1;
					fin_go = !pend_q || out_ok;
					push = pend_q && out_ok;
				end
				default: ;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign raddr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			armed_q <= '0;
			pend_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						func_q <= func;
						pos_q <= key_position;
						t_q <= time_ms;
						idx_q <= '0;
						found_q <= 1'b0;
						pend_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (ev_go) begin
						if ((func_q == FN_PRESS || func_q == FN_OTHER) &&
						    valid_q[idx_q] && !hit) begin
							armed_q[idx_q] <= 1'b0;
						end
						if ((func_q == FN_PRESS || func_q == FN_RELEASE) && hit &&
						    !found_q) begin
							found_q <= 1'b1;
							fidx_q <= idx_q;
							fdata_q <= rdata;
						end
						if (func_q == FN_TICK && expired) begin
							valid_q[idx_q] <= 1'b0;
							armed_q[idx_q] <= 1'b0;
						end
						if (tick_emit) begin
							pend_q <= 1'b1;
							pend_res_q <= tick_res;
						end
						if (idx_q == IDX_W'(ENTRIES - 1)) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						if (func_q == FN_PRESS && (found_q || free_ok)) begin
							valid_q[tgt_idx] <= 1'b1;
							armed_q[tgt_idx] <= (term != '0);
						end
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/key_tap_dance_tracker_unit.sv */
// top level of the tap-dance tracker: config registers, entry ram, scan engine, output register
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   func, key_position, time_ms
// out      from block out_valid / out_stall action, binding_index, out_position, out_time,
//                                           status, last
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// each item scans all entries through the ram read port, with a read state and an evaluate
// state per entry, then one finish state.
// in_stall is high from acceptance until the scan ends and its last result, if any, is loaded into the output register.
// a stalled output holds the scan at the next result to emit; arst_n empties the table.
module key_tap_dance_tracker_unit import ktd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [POS_W-1:0]  key_position,
	input  logic [TIME_W-1:0] time_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        action,
	output logic [3:0]        binding_index,
	output logic [POS_W-1:0]  out_position,
	output logic [TIME_W-1:0] out_time,
	output logic [1:0]        status,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [TERM_W-1:0] cfg_data
);
	logic [TERM_W-1:0] term_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              busy, push, we, out_ok;
	result_t           res;
	logic [IDX_W-1:0]  waddr, raddr;
	entry_t            wdata, rdata;
	logic [WORD_W-1:0] rword;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;
	assign out_ok = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TERM:  term_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	ktd_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rword)
	);
	assign rdata = entry_t'(rword);

	ktd_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_go        (in_valid && !busy),
		.func         (func),
		.key_position (key_position),
		.time_ms      (time_ms),
		.term         (term_q),
		.bcount       (count_q),
		.out_ok       (out_ok),
		.busy         (busy),
		.push         (push),
		.res          (res),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.rdata        (rdata)
	);

	assign out_valid = out_valid_q;
	assign action = out_q.action;
	assign binding_index = out_q.binding_index;
	assign out_position = out_q.position;
	assign out_time = out_q.time_ms;
	assign status = out_q.status;
	assign last = out_q.last;
endmodule

/* rtl/ktd_checker.sv */
// port-level checks of the tap-dance tracker and their binding
`include "key_tap_dance_tracker_unit_assert.svh"
module ktd_checker import ktd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] action,
	input logic [1:0] status,
	input logic       last
);
	// a status result is always the only result of its transaction
	`KTD_ASSERT_SAME(a_status_last, clk, arst_n, out_valid && status != ST_OK, last && action == ACT_NONE)
	// nothing emitted only happens with a status
	`KTD_ASSERT_SAME(a_none_status, clk, arst_n, out_valid && action == ACT_NONE, status != ST_OK)
	// an accepted item keeps the input side busy while it is scanned
	`KTD_ASSERT_NEXT(a_busy_after, clk, arst_n, in_valid && !in_stall, in_stall)
	`KTD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
endmodule

bind key_tap_dance_tracker_unit ktd_checker u_ktd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.action    (action),
	.status    (status),
	.last      (last)
);

/* dv/key_tap_dance_tracker_unit_tb.sv */
// testbench of the tap-dance tracker: random and directed key events checked against a predictor
module key_tap_dance_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ktd_pkg::*;

	typedef struct {
		logic [1:0]  action;
		logic [3:0]  binding_index;
		logic [7:0]  position;
		logic [31:0] stamp;
		logic [1:0]  status;
		logic        last;
	} dance_result_t;

	class dance_scoreboard;
		logic [15:0] term;
		logic [4:0]  count;
		bit          used [ENTRIES];
		logic [7:0]  pos_of [ENTRIES];
		logic [4:0]  taps [ENTRIES];
		bit          held [ENTRIES];
		bit          armed [ENTRIES];
		logic [31:0] due [ENTRIES];
		dance_result_t pending[$];
		int          errors;

		function new();
			term = TERM_RESET;
			count = COUNT_RESET;
			errors = 0;
			foreach (used[i]) begin
				used[i] = 0;
				armed[i] = 0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] data);
			if (idx == REG_TERM)
				term = data;
			else if (idx == REG_COUNT)
				count = data[4:0];
		endfunction

		function int lookup(logic [7:0] pos);
			for (int i = 0; i < ENTRIES; i++)
				if (used[i] && pos_of[i] == pos)
					return i;
			return -1;
		endfunction

		function void push(logic [1:0] act, logic [3:0] bi, logic [7:0] p, logic [31:0] t,
			logic [1:0] st, logic l);
			dance_result_t r;
			r.action = act;
			r.binding_index = bi;
			r.position = p;
			r.stamp = t;
			r.status = st;
			r.last = l;
			pending.push_back(r);
		endfunction

		function void note_input(logic [1:0] fn, logic [7:0] pos, logic [31:0] t);
			int i;
			int cap;
			int n;
			cap = (count < 1) ? 1 : (count > MAX_BINDINGS) ? MAX_BINDINGS : count;
			if (fn == FN_PRESS || fn == FN_OTHER)
				for (int k = 0; k < ENTRIES; k++)
					if (used[k] && pos_of[k] != pos)
						armed[k] = 0;
			if (fn == FN_PRESS) begin
				i = lookup(pos);
				if (i < 0) begin
					for (i = 0; i < ENTRIES; i++)
						if (!used[i])
							break;
					if (i >= ENTRIES) begin
						push(ACT_NONE, 4'd0, pos, t, ST_FULL, 1'b1);
						return;
					end
					used[i] = 1;
					pos_of[i] = pos;
					taps[i] = 0;
				end
				held[i] = 1;
				if (taps[i] < cap)
					taps[i]++;
				push(ACT_PRESS, 4'(taps[i] - 5'd1), pos, t, ST_OK, 1'b1);
				due[i] = t + term;
				armed[i] = (term != 0);
			end else if (fn == FN_RELEASE) begin
				i = lookup(pos);
				if (i < 0) begin
					push(ACT_NONE, 4'd0, pos, t, ST_NO_ENTRY, 1'b1);
				end else begin
					held[i] = 0;
					push(ACT_RELEASE, 4'(taps[i] - 5'd1), pos, t, ST_OK, 1'b1);
				end
			end else if (fn == FN_TICK) begin
				n = 0;
				for (int k = 0; k < ENTRIES; k++) begin
					if (!used[k] || !armed[k])
						continue;
					if (((t - due[k]) & 32'h8000_0000) != 0)
						continue;
					used[k] = 0;
					armed[k] = 0;
					if (!held[k]) begin
						push(ACT_RELEASE, 4'(taps[k] - 5'd1), pos_of[k], due[k], ST_OK, 1'b0);
						n++;
					end
				end
				if (n > 0)
					pending[$].last = 1'b1;
			end
		endfunction

		function void check_result(dance_result_t got);
			dance_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.action !== e.action) begin
				$error("action exp %0d got %0d", e.action, got.action);
				errors++;
			end
			if (got.binding_index !== e.binding_index) begin
				$error("binding_index exp %0d got %0d", e.binding_index, got.binding_index);
				errors++;
			end
			if (got.position !== e.position) begin
				$error("out_position exp %0d got %0d", e.position, got.position);
				errors++;
			end
			if (got.stamp !== e.stamp) begin
				$error("out_time exp %0h got %0h", e.stamp, got.stamp);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last exp %0d got %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [POS_W-1:0]  key_position;
	logic [TIME_W-1:0] time_ms;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        action;
	logic [3:0]        binding_index;
	logic [POS_W-1:0]  out_position;
	logic [TIME_W-1:0] out_time;
	logic [1:0]        status;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [TERM_W-1:0] cfg_data;

	dance_scoreboard board;
	logic [31:0] now_ms;
	bit          quiet;
	bit          hold_off;
	logic [7:0]  keys [4];

	key_tap_dance_tracker_unit u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("key_tap_dance_tracker_unit verification failed");
		$finish;
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.set_reg(idx, data);
	endtask

	task automatic send(logic [1:0] fn, logic [7:0] pos, logic [31:0] t);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= fn;
		key_position <= pos;
		time_ms <= t;
		do @(posedge clk); while (in_stall);
		board.note_input(fn, pos, t);
		in_valid <= 0;
		// the block is busy with this transaction for this cycle anyway
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
		// ticks may still be scanning with nothing to emit
		repeat (60) @(posedge clk);
	endtask

	// result side: random stall bursts, plus one long hold-off
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		dance_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.action = action;
			r.binding_index = binding_index;
			r.position = out_position;
			r.stamp = out_time;
			r.status = status;
			r.last = last;
			board.check_result(r);
		end
	end

	task automatic random_item();
		int sel;
		logic [7:0] k;
		sel = $urandom_range(0, 99);
		k = ($urandom_range(0, 9) == 0) ? 8'($urandom) : keys[$urandom_range(0, 3)];
		now_ms = now_ms + $urandom_range(0, 150);
		if (sel < 35)
			send(FN_PRESS, k, now_ms);
		else if (sel < 65)
			send(FN_RELEASE, k, now_ms);
		else if (sel < 72)
			send(FN_OTHER, k, now_ms);
		else if (sel < 97)
			send(FN_TICK, 8'($urandom), now_ms);
		else
			send(FN_TICK, 8'($urandom), $urandom);
	endtask

	initial begin
		board = new();
		arst_n = 0;
		in_valid = 0;
		func = FN_TICK;
		key_position = 0;
		time_ms = 0;
		cfg_valid = 0;
		cfg_index = REG_TERM;
		cfg_data = 0;
		quiet = 0;
		hold_off = 0;
		now_ms = 32'hFFFF_FF00;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: taps saturating, release, expiry, wrap of time
		send(FN_RELEASE, 8'hFF, 32'h0);
		send(FN_PRESS, 8'h00, now_ms);
		send(FN_PRESS, 8'h00, now_ms + 10);
		send(FN_PRESS, 8'h00, now_ms + 20);
		send(FN_RELEASE, 8'h00, now_ms + 30);
		send(FN_PRESS, 8'hFF, now_ms + 40);
		send(FN_OTHER, 8'hFF, now_ms + 50);
		send(FN_TICK, 8'h00, now_ms + 300);
		send(FN_RELEASE, 8'hFF, now_ms + 310);
		send(FN_TICK, 8'h00, now_ms + 320);
		// fill the table and overflow
		for (int i = 0; i <= ENTRIES; i++)
			send(FN_PRESS, 8'(i + 16), 32'h7FFF_FFFF);
		send(FN_OTHER, 8'h5A, 32'h8000_0000);
		send(FN_TICK, 8'hA5, 32'hFFFF_FFFF);
		drain();
		write_reg(REG_TERM, 16'd0);
		write_reg(REG_COUNT, 16'd0);
		for (int i = 0; i < 11; i++)
			send(FN_RELEASE, 8'(i + 16), 32'h0);
		send(FN_TICK, 8'h00, 32'h0);
		drain();

		// random phases: ticks under a zero term clear nothing, so each phase writes a fresh term and sends some large ticks
		keys[0] = 8'h00;
		keys[1] = 8'h55;
		keys[2] = 8'hAA;
		keys[3] = 8'hFF;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_reg(REG_TERM, 16'hFFFF); write_reg(REG_COUNT, 16'd31); end
				1: begin write_reg(REG_TERM, 16'd1); write_reg(REG_COUNT, 16'd16); end
				2: begin write_reg(REG_TERM, 16'd120); write_reg(REG_COUNT, 16'd1); end
				3: begin write_reg(REG_TERM, 16'd200); write_reg(REG_COUNT, 16'd3); end
				default: begin write_reg(REG_TERM, 16'd90); write_reg(REG_COUNT, 16'd5); end
			endcase
			if (phase == 2)
				hold_off = 1;
			if (phase == 4)
				quiet = 1;
			for (int j = 0; j < 66; j++)
				random_item();
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("key_tap_dance_tracker_unit verification clean");
		else
			$display("key_tap_dance_tracker_unit verification failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/ktd_pkg.sv
rtl/ktd_ram.sv
rtl/ktd_engine.sv
rtl/key_tap_dance_tracker_unit.sv
rtl/ktd_checker.sv
dv/key_tap_dance_tracker_unit_tb.sv
